>>> rtl/core/spl_pkg.sv
`default_nettype none

package spl_pkg;

  // command codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } spl_op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } spl_status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_RD_HEAD,
    S_DEL
  } spl_state_e;

  localparam int unsigned PosW   = 5;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HdlW   = 16;

  // one stored table entry
  typedef struct packed {
    logic [PrioW-1:0]  prio;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HdlW-1:0]   handle;
  } spl_entry_t;

  // command word
  typedef struct packed {
    logic [1:0]        command;
    logic [PosW-1:0]   position;
    logic [PrioW-1:0]  prio;
    logic [YearW-1:0]  due_year;
    logic [MonthW-1:0] due_month;
    logic [DayW-1:0]   due_day;
    logic [HdlW-1:0]   entry_handle;
  } spl_cmd_t;

  // result word
  typedef struct packed {
    logic [1:0]        status;
    logic [4:0]        entry_count;
    logic [PrioW-1:0]  out_prio;
    logic [YearW-1:0]  out_year;
    logic [MonthW-1:0] out_month;
    logic [DayW-1:0]   out_day;
    logic [HdlW-1:0]   out_handle;
  } spl_res_t;

endpackage

`default_nettype wire

>>> rtl/core/spl_store.sv
`default_nettype none

module spl_store import spl_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire spl_entry_t       wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output spl_entry_t            rdata_o
);

  spl_entry_t mem [Depth];
  spl_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/spl_seq.sv
`default_nettype none

module spl_seq import spl_pkg::*; #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned AddrW    = 4,
  parameter int unsigned CntW     = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire spl_cmd_t         cmd_i,
  output logic                  busy_o,
  output logic                  done_o,
  output spl_res_t              res_o,
  output logic                  we_o,
  output logic [AddrW-1:0]      waddr_o,
  output spl_entry_t            wdata_o,
  output logic [AddrW-1:0]      raddr_o,
  input  wire spl_entry_t       rdata_i
);

  localparam int unsigned PCW = (CntW > PosW) ? CntW : PosW;

  spl_state_e        state_q, state_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]   count_q, count_d;
  spl_entry_t        new_q, new_d;
  logic              del_q, del_d;
  spl_res_t          res_q, res_d;
  logic              done_q, done_d;

  spl_entry_t        in_entry;
  logic [PCW-1:0]    pos_ext, cnt_ext, cnt_inc_ext, cnt_dec_ext;
  logic [PosW-1:0]   pos_m1;
  logic [AddrW-1:0]  idx_p1, idx_m1;
  logic [AddrW+1:0]  idx_p2;
  logic [AddrW+1:0]  cnt_wide;
  logic              is_full, is_empty, bad_pos;

  // entry built from the command word
  assign in_entry.prio   = cmd_i.prio;
  assign in_entry.year   = cmd_i.due_year;
  assign in_entry.month  = cmd_i.due_month;
  assign in_entry.day    = cmd_i.due_day;
  assign in_entry.handle = cmd_i.entry_handle;

  // index and count arithmetic
  assign pos_ext     = PCW'(cmd_i.position);
  assign cnt_ext     = PCW'(count_q);
  assign cnt_inc_ext = PCW'(count_q) + PCW'(1);
  assign cnt_dec_ext = PCW'(count_q) - PCW'(1);
  assign pos_m1      = cmd_i.position - PosW'(1);
  assign idx_p1      = idx_q + AddrW'(1);
  assign idx_m1      = idx_q - AddrW'(1);
  assign idx_p2      = (AddrW+2)'(idx_q) + (AddrW+2)'(2);
  assign cnt_wide    = (AddrW+2)'(count_q);
  assign is_full     = (count_q == CntW'(Capacity));
  assign is_empty    = (count_q == '0);
  assign bad_pos     = (cmd_i.position == '0) || (pos_ext > cnt_ext);

  // state and data registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    new_q <= new_d;
    del_q <= del_d;
    res_q <= res_d;
  end

  // sequencer: one table slot per cycle through the memory port
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    new_d   = new_q;
    del_d   = del_q;
    res_d   = res_q;
    done_d  = 1'b0;
    we_o    = 1'b0;
    waddr_o = idx_p1;
    wdata_o = rdata_i;
    raddr_o = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d             = '0;
          res_d.status      = ST_OK;
          res_d.entry_count = cnt_ext[4:0];
          unique case (cmd_i.command)
            OP_INSERT: begin
              if (is_full) begin
                res_d.status = ST_FULL;
                done_d       = 1'b1;
              end else if (is_empty) begin
                // first entry goes straight to slot zero
                we_o              = 1'b1;
                waddr_o           = '0;
                wdata_o           = in_entry;
                count_d           = CntW'(1);
                res_d.entry_count = cnt_inc_ext[4:0];
                res_d.out_prio    = in_entry.prio;
                res_d.out_year    = in_entry.year;
                res_d.out_month   = in_entry.month;
                res_d.out_day     = in_entry.day;
                res_d.out_handle  = in_entry.handle;
                done_d            = 1'b1;
              end else begin
                // walk down from the last entry
                new_d   = in_entry;
                idx_d   = AddrW'(cnt_dec_ext);
                raddr_o = AddrW'(cnt_dec_ext);
                state_d = S_INS;
              end
            end
            OP_DELETE, OP_READ: begin
              if (bad_pos) begin
                res_d.status = ST_BAD_POS;
                done_d       = 1'b1;
              end else begin
                del_d   = (cmd_i.command == OP_DELETE);
                idx_d   = AddrW'(pos_m1);
                raddr_o = AddrW'(pos_m1);
                state_d = S_RD_HEAD;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        if (rdata_i.prio > new_q.prio) begin
          // move this entry up one slot
          we_o    = 1'b1;
          waddr_o = idx_p1;
          wdata_o = rdata_i;
          if (idx_q == '0) begin
            state_d = S_INS_LAST;
          end else begin
            idx_d   = idx_m1;
            raddr_o = idx_m1;
          end
        end else begin
          // new entry lands after this one
          we_o              = 1'b1;
          waddr_o           = idx_p1;
          wdata_o           = new_q;
          count_d           = count_q + CntW'(1);
          res_d.entry_count = cnt_inc_ext[4:0];
          res_d.out_prio    = new_q.prio;
          res_d.out_year    = new_q.year;
          res_d.out_month   = new_q.month;
          res_d.out_day     = new_q.day;
          res_d.out_handle  = new_q.handle;
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_INS_LAST: begin
        // new entry sorts before everything held
        we_o              = 1'b1;
        waddr_o           = '0;
        wdata_o           = new_q;
        count_d           = count_q + CntW'(1);
        res_d.entry_count = cnt_inc_ext[4:0];
        res_d.out_prio    = new_q.prio;
        res_d.out_year    = new_q.year;
        res_d.out_month   = new_q.month;
        res_d.out_day     = new_q.day;
        res_d.out_handle  = new_q.handle;
        done_d            = 1'b1;
        state_d           = S_IDLE;
      end

      S_RD_HEAD: begin
        res_d.out_prio   = rdata_i.prio;
        res_d.out_year   = rdata_i.year;
        res_d.out_month  = rdata_i.month;
        res_d.out_day    = rdata_i.day;
        res_d.out_handle = rdata_i.handle;
        if (!del_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (((AddrW+2)'(idx_q) + (AddrW+2)'(1)) < cnt_wide) begin
          // later entries follow, close the gap
          raddr_o = idx_p1;
          state_d = S_DEL;
        end else begin
          count_d           = count_q - CntW'(1);
          res_d.entry_count = cnt_dec_ext[4:0];
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_DEL: begin
        // rdata holds the entry above idx, move it down
        we_o    = 1'b1;
        waddr_o = idx_q;
        wdata_o = rdata_i;
        if (idx_p2 < cnt_wide) begin
          idx_d   = idx_p1;
          raddr_o = AddrW'(idx_p2);
        end else begin
          count_d           = count_q - CntW'(1);
          res_d.entry_count = cnt_dec_ext[4:0];
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> rtl/core/sorted_priority_list.sv
// error, full and unused commands and an insert into an empty table finish from idle;
//   reads fetch one entry, deletes move later entries down, inserts move larger ones up
// throughput: one command at a time, busy_o stays high until the result word
//   is shown; the entry memory, one read and one write port, moves one slot per cycle
// reset: rst_ni asynchronous, clears the entry count and the sequencer
// results are shown for one cycle on done_o, the receiver cannot stall them
`default_nettype none

module sorted_priority_list import spl_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire spl_cmd_t cmd_i,
  output logic          busy_o,
  output logic          done_o,
  output spl_res_t      res_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  spl_entry_t       wdata;
  spl_entry_t       rdata;

  // command sequencer
  spl_seq #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .res_o   (res_o),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  // entry table
  spl_store #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/spl_checker.sv
`default_nettype none

module spl_checker import spl_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start_i,
  input wire logic     busy_o,
  input wire logic     done_o,
  input wire spl_res_t res_o
);

  // an accepted word either completes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted word neither busy nor done");

  // the result word appears only once the block is free again
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // busy only starts from an accepted word
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy without accepted word");

  // refused commands carry an empty entry
  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status != ST_OK) |->
      (res_o.out_prio == '0) && (res_o.out_year == '0) && (res_o.out_month == '0) &&
      (res_o.out_day == '0) && (res_o.out_handle == '0))
    else $error("error result with entry data");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.status == ST_OK) || (res_o.status == ST_FULL) ||
               (res_o.status == ST_BAD_POS))
    else $error("undefined status code");

endmodule

bind sorted_priority_list spl_checker u_spl_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);

`default_nettype wire
